// ===== rtl/core/ecal_pkg.sv =====
// ----------------------------------------------------------------------------
// ecal_pkg
// shared types, constants and a lookup function for the epoch to calendar
// converter
// ----------------------------------------------------------------------------
package ecal_pkg;

    localparam logic [10:0] BASE_YEAR    = 11'd1970;
    localparam logic [6:0]  BASE_MOD100  = 7'd70;
    localparam logic [8:0]  BASE_MOD400  = 9'd370;
    localparam logic [3:0]  DIV_STEPS    = 4'd5;
    localparam logic [3:0]  LAST_MONTH   = 4'd11;
    localparam logic [2:0]  EPOCH_WDAY   = 3'd4;

    // rounded-up reciprocals, exact over the operand ranges they see
    localparam logic [24:0] RECIP_675    = 25'd25451659;   // 2^34 / 675
    localparam logic [15:0] RECIP_7      = 16'd37450;      // 2^18 / 7
    localparam logic [15:0] RECIP_15     = 16'd34953;      // 2^19 / 15

    typedef struct packed {
        logic load;
        logic div_step;
        logic cal_step;
        logic mon_step;
        logic capture;
    } ecal_cmd_t;

    typedef struct packed {
        logic div_last;
        logic cal_done;
        logic mon_done;
    } ecal_status_t;

    // month length, index 0 is january
    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/ecal_datapath.sv =====
// ----------------------------------------------------------------------------
// ecal_datapath
// day division, year and month walk, time of day split and result registers
// ----------------------------------------------------------------------------
module ecal_datapath (
    input  logic                 aclk,
    input  ecal_pkg::ecal_cmd_t  cmd,
    output ecal_pkg::ecal_status_t status,
    input  logic [30:0]          epoch_seconds,
    output logic [10:0]          year,
    output logic [3:0]           month,
    output logic [4:0]           day_of_month,
    output logic [2:0]           weekday,
    output logic [4:0]           hour,
    output logic [5:0]           minute,
    output logic [5:0]           second
);
    import ecal_pkg::*;

    logic [30:0] secs_reg, secs_next;
    logic [14:0] days_reg, days_next;
    logic [3:0]  div_cnt_reg, div_cnt_next;
    logic [16:0] tod_reg, tod_next;
    logic [12:0] q7_reg, q7_next;
    logic [2:0]  wmod_reg, wmod_next;
    logic [10:0] mt_reg, mt_next;
    logic [5:0]  sec_reg, sec_next;
    logic [10:0] year_reg, year_next;
    logic [6:0]  mod100_reg, mod100_next;
    logic [8:0]  mod400_reg, mod400_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;

    logic [10:0] out_year_reg;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;
    logic [2:0]  out_wday_reg;
    logic [4:0]  out_hour_reg;
    logic [5:0]  out_min_reg;
    logic [5:0]  out_sec_reg;

    logic [48:0] day_prod;
    logic [23:0] day_back;
    logic [23:0] day_rem;
    logic [30:0] wk_prod;
    logic [15:0] wk_back;
    logic [14:0] wk_rem;
    logic [30:0] mt_prod;
    logic [16:0] mt_back;
    logic [16:0] sec_rem;
    logic [30:0] hr_prod;
    logic [10:0] hr_back;
    logic [10:0] min_rem;
    logic        leap;
    logic [8:0]  ylen;
    logic        year_fit;
    logic [4:0]  mlen;
    logic        mon_fit;
    logic [3:0]  wsum;
    logic [2:0]  wday0;

    // 86400 = 128 * 675: days from the top 24 bits, remainder rebuilt below
    assign day_prod = {25'd0, secs_reg[30:7]} * {24'd0, RECIP_675};
    assign day_back = {9'd0, days_reg} * 24'd675;
    assign day_rem  = secs_reg[30:7] - day_back;

    // day count mod 7 for the weekday
    assign wk_prod  = {16'd0, days_reg} * {15'd0, RECIP_7};
    assign wk_back  = {3'd0, q7_reg} * 16'd7;
    assign wk_rem   = days_reg - wk_back[14:0];

    // minutes of the day, then seconds
    assign mt_prod  = {16'd0, tod_reg[16:2]} * {15'd0, RECIP_15};
    assign mt_back  = {6'd0, mt_reg} * 17'd60;
    assign sec_rem  = tod_reg - mt_back;

    // hours, then minutes of the hour
    assign hr_prod  = {22'd0, mt_reg[10:2]} * {15'd0, RECIP_15};
    assign hr_back  = {6'd0, hour_reg} * 11'd60;
    assign min_rem  = mt_reg - hr_back;

    // leap rule from running year residues
    assign leap     = (mod400_reg == 9'd0) || ((mod100_reg != 7'd0) && (year_reg[1:0] == 2'd0));
    assign ylen     = leap ? 9'd366 : 9'd365;
    assign year_fit = days_reg < {6'd0, ylen};

    assign mlen     = month_length(month_reg, leap);
    assign mon_fit  = (month_reg == LAST_MONTH) || (days_reg < {10'd0, mlen});

    assign wsum     = {1'b0, wmod_reg} + {1'b0, EPOCH_WDAY};
    assign wday0    = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];

    assign status.div_last = div_cnt_reg == 4'(DIV_STEPS - 4'd1);
    assign status.cal_done = year_fit;
    assign status.mon_done = mon_fit;

    always_comb begin
        secs_next    = secs_reg;
        days_next    = days_reg;
        div_cnt_next = div_cnt_reg;
        tod_next     = tod_reg;
        q7_next      = q7_reg;
        wmod_next    = wmod_reg;
        mt_next      = mt_reg;
        sec_next     = sec_reg;
        year_next    = year_reg;
        mod100_next  = mod100_reg;
        mod400_next  = mod400_reg;
        month_next   = month_reg;
        hour_next    = hour_reg;
        min_next     = min_reg;
        if (cmd.load) begin
            secs_next    = epoch_seconds;
            div_cnt_next = '0;
            year_next    = BASE_YEAR;
            mod100_next  = BASE_MOD100;
            mod400_next  = BASE_MOD400;
            month_next   = '0;
        end else if (cmd.div_step) begin
            // each stage reads the one before, so the chain settles in five steps
            days_next    = day_prod[48:34];
            tod_next     = {day_rem[9:0], secs_reg[6:0]};
            q7_next      = wk_prod[30:18];
            wmod_next    = wk_rem[2:0];
            mt_next      = mt_prod[29:19];
            sec_next     = sec_rem[5:0];
            hour_next    = hr_prod[23:19];
            min_next     = min_rem[5:0];
            div_cnt_next = div_cnt_reg + 4'd1;
        end else if (cmd.cal_step) begin
            if (!year_fit) begin
                days_next   = days_reg - {6'd0, ylen};
                year_next   = year_reg + 11'd1;
                mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
            end
        end else if (cmd.mon_step) begin
            if (!mon_fit) begin
                days_next  = days_reg - {10'd0, mlen};
                month_next = month_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        secs_reg    <= secs_next;
        days_reg    <= days_next;
        div_cnt_reg <= div_cnt_next;
        tod_reg     <= tod_next;
        q7_reg      <= q7_next;
        wmod_reg    <= wmod_next;
        mt_reg      <= mt_next;
        sec_reg     <= sec_next;
        year_reg    <= year_next;
        mod100_reg  <= mod100_next;
        mod400_reg  <= mod400_next;
        month_reg   <= month_next;
        hour_reg    <= hour_next;
        min_reg     <= min_next;
        if (cmd.capture) begin
            out_year_reg  <= year_reg;
            out_month_reg <= month_reg + 4'd1;
            out_day_reg   <= days_reg[4:0] + 5'd1;
            out_wday_reg  <= wday0 + 3'd1;
            out_hour_reg  <= hour_reg;
            out_min_reg   <= min_reg;
            out_sec_reg   <= sec_reg;
        end
    end

    assign year         = out_year_reg;
    assign month        = out_month_reg;
    assign day_of_month = out_day_reg;
    assign weekday      = out_wday_reg;
    assign hour         = out_hour_reg;
    assign minute       = out_min_reg;
    assign second       = out_sec_reg;

endmodule

// ===== rtl/core/ecal_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecal_ctrl
// sequencer for the converter: divide, year walk, month walk, hand-off
// ----------------------------------------------------------------------------
module ecal_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ecal_pkg::ecal_cmd_t    cmd,
    input  ecal_pkg::ecal_status_t status
);
    import ecal_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CAL,
        ST_MON,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_CAL;
                end
            end
            ST_CAL: begin
                cmd.cal_step = 1'b1;
                if (status.cal_done) begin
                    state_next = ST_MON;
                end
            end
            ST_MON: begin
                cmd.mon_step = 1'b1;
                if (status.mon_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for the result register to be free
                if (!m_valid_reg || m_ready) begin
                    cmd.capture  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// seconds since 1970-01-01 00:00:00 to gregorian date, weekday and time of day
// ----------------------------------------------------------------------------
// sequence from input transaction to m_valid: 5 divide steps, the year walk,
//   the month walk and the hand-off
// flow: one transaction at a time; a new input is taken once the previous
//   result sits in the output register, so a waiting result holds back only
//   the next hand-off
// reset: synchronous active-low aresetn clears the sequencer and m_valid only
module epoch_seconds_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [30:0] s_epoch_seconds,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day_of_month,
    output logic [2:0]  m_weekday,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second
);
    import ecal_pkg::*;

    // command and status between sequencer and datapath
    ecal_cmd_t    cmd;
    ecal_status_t status;

    // sequencer: idle, divide and time split, year walk, month walk, hand-off
    ecal_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // datapath: day division and time split by reciprocal multiplication,
    // year and month subtraction, output register
    ecal_datapath u_dp (
        .aclk          (aclk),
        .cmd           (cmd),
        .status        (status),
        .epoch_seconds (s_epoch_seconds),
        .year          (m_year),
        .month         (m_month),
        .day_of_month  (m_day_of_month),
        .weekday       (m_weekday),
        .hour          (m_hour),
        .minute        (m_minute),
        .second        (m_second)
    );

`ifndef NO_ASSERTIONS
    // a transaction taken closes the input until the result is handed off
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while conversion in flight");

    // date fields in range whenever a result is offered
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month >= 4'd1) && (m_month <= 4'd12) && (m_day_of_month != 5'd0)
                    && (m_weekday != 3'd0))
        else $error("date field out of range");

    // time of day fields in range whenever a result is offered
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hour < 5'd24) && (m_minute < 6'd60) && (m_second < 6'd60))
        else $error("time field out of range");
`endif

endmodule
